>>> rtl/core/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg
// Shared constants, types and elaboration-time functions for the gamma
// lookup table correction core.
// ----------------------------------------------------------------------------
package glc_pkg;

  // Sample and table geometry
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned TBL_DEPTH  = 2 ** PIXEL_W;

  // Gamma select register
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned NUM_SEL    = 2 ** SEL_W;
  localparam logic [SEL_W-1:0] SEL_BYPASS = SEL_W'(3);
  localparam logic [SEL_W-1:0] SEL_LAST   = SEL_W'(6);

  // Gamma as a ratio num/den; the last code is unused and kept at unity
  localparam int unsigned GAM_NUM [NUM_SEL] = '{11, 17, 29, 1, 20, 10, 5, 1};
  localparam int unsigned GAM_DEN [NUM_SEL] = '{5, 10, 20, 1, 29, 17, 11, 1};

  // Default fixed-point fraction of the gain
  localparam int unsigned FRACTION_BITS_DEF = 13;

  // Log ROM geometry
  localparam int unsigned LOG_ENTRIES = 510;
  localparam int unsigned LOG_ADDR_W  = 9;
  localparam int unsigned LOG_DEPTH   = 2 ** LOG_ADDR_W;
  localparam int unsigned LOG_W       = 31;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned LN_FRAC     = 60;
  localparam int unsigned RATIO_BITS  = 40;

  typedef logic [LOG_W-1:0] log_rom_t [LOG_DEPTH];

  // Table builder sequencer states
  typedef enum logic [1:0] {
    BLD_IDLE,
    BLD_ZERO,
    BLD_MUL,
    BLD_WALK
  } bld_state_t;

  // Configuration command to the builder
  typedef struct packed {
    logic             restart;
    logic [SEL_W-1:0] sel;
  } glc_cmd_t;

  // Table write port
  typedef struct packed {
    logic               we;
    logic [PIXEL_W-1:0] addr;
    logic [PIXEL_W-1:0] data;
  } glc_tbl_wr_t;

  // Builder status
  typedef struct packed {
    logic busy;
    logic done;
  } glc_bld_status_t;

  // True for a select code that needs a table
  function automatic logic is_gamma(logic [SEL_W-1:0] sel);
    return (sel inside {[0:SEL_LAST]}) && (sel != SEL_BYPASS);
  endfunction

  // Shift-subtract division, used only while building constants
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Scaled log ROM: round(ln(510/i) * (2^31-1) / ln 510), entry 0 and
  // entries past the end are zero. ln(n) is summed from
  // ln(n/(n-1)) = 2 atanh(1/(2n-1)) in Q60.
  function automatic log_rom_t build_log_rom();
    log_rom_t        rom;
    longint unsigned lnv [LOG_DEPTH];
    longint unsigned m;
    longint unsigned mm;
    longint unsigned pw;
    longint unsigned sum;
    longint unsigned odd;
    longint unsigned whole;
    longint unsigned rem;
    longint unsigned q;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned adj;
    longint unsigned val;
    for (int n = 0; n < LOG_DEPTH; n++) begin
      lnv[n] = 64'd0;
      rom[n] = '0;
    end
    for (int n = 2; n <= LOG_ENTRIES; n++) begin
      m   = 64'(2 * n - 1);
      mm  = m * m;
      pw  = udiv64(64'd1 << LN_FRAC, m);
      sum = 64'd0;
      odd = 64'd1;
      while (pw != 64'd0) begin
        sum = sum + udiv64(pw, odd);
        pw  = udiv64(pw, mm);
        odd = odd + 64'd2;
      end
      lnv[n] = lnv[n-1] + 64'd2 * sum;
    end
    whole = lnv[LOG_ENTRIES];
    for (int i = 1; i <= LOG_ENTRIES; i++) begin
      rem = whole - lnv[i];
      q   = 64'd0;
      if (rem >= whole) begin
        rem = rem - whole;
        q   = 64'd1;
      end
      for (int b = 0; b < RATIO_BITS; b++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= whole) begin
          rem = rem - whole;
          q   = q | 64'd1;
        end
      end
      // Round q * (2^31 - 1) / 2^40, half up
      hi  = q >> (RATIO_BITS - LOG_W);
      lo  = q & ((64'd1 << (RATIO_BITS - LOG_W)) - 64'd1);
      adj = (lo << LOG_W) + (64'd1 << (RATIO_BITS - 1))
          + (64'd1 << (RATIO_BITS + 2)) - q;
      val = hi + (adj >> RATIO_BITS) - 64'd4;
      rom[i] = val[LOG_W-1:0];
    end
    return rom;
  endfunction

endpackage

>>> rtl/core/glc_ram.sv
// ----------------------------------------------------------------------------
// glc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/glc_log_rom.sv
// ----------------------------------------------------------------------------
// glc_log_rom
// Fixed scaled-logarithm ROM with registered read, contents computed at
// elaboration.
// ----------------------------------------------------------------------------
module glc_log_rom (
  input  logic                           clk,
  input  logic [glc_pkg::LOG_ADDR_W-1:0] addr,
  output logic [glc_pkg::LOG_W-1:0]      data
);
  import glc_pkg::*;

  localparam log_rom_t LOG_ROM = build_log_rom();

  // Registered read
  always_ff @(posedge clk) begin
    data <= LOG_ROM[addr];
  end

endmodule

>>> rtl/core/glc_table_builder.sv
// ----------------------------------------------------------------------------
// glc_table_builder
// Rebuilds the gamma table by one monotone pointer walk over the log ROM,
// sharing a single ROM port and a single compare under a small sequencer.
// ----------------------------------------------------------------------------
module glc_table_builder #(
  parameter int unsigned FRACTION_BITS = glc_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  glc_pkg::glc_cmd_t        cmd,
  output glc_pkg::glc_tbl_wr_t     tbl_wr,
  output glc_pkg::glc_bld_status_t status
);
  import glc_pkg::*;

  localparam int unsigned GAIN_W  = FRACTION_BITS + 2;
  localparam int unsigned PROD_W  = KEY_W;
  localparam logic [PIXEL_W-1:0]    IDX_FIRST = PIXEL_W'(1);
  localparam logic [PIXEL_W-1:0]    IDX_LAST  = PIXEL_W'(TBL_DEPTH - 1);
  localparam logic [LOG_ADDR_W-1:0] PTR_FIRST = LOG_ADDR_W'(1);
  localparam logic [LOG_ADDR_W-1:0] PTR_END   = LOG_ADDR_W'(LOG_ENTRIES);

  // Gain per select code: floor(gamma * 2^FRACTION_BITS)
  localparam logic [GAIN_W-1:0] GAIN [NUM_SEL] = '{
    GAIN_W'((GAM_NUM[0] << FRACTION_BITS) / GAM_DEN[0]),
    GAIN_W'((GAM_NUM[1] << FRACTION_BITS) / GAM_DEN[1]),
    GAIN_W'((GAM_NUM[2] << FRACTION_BITS) / GAM_DEN[2]),
    GAIN_W'((GAM_NUM[3] << FRACTION_BITS) / GAM_DEN[3]),
    GAIN_W'((GAM_NUM[4] << FRACTION_BITS) / GAM_DEN[4]),
    GAIN_W'((GAM_NUM[5] << FRACTION_BITS) / GAM_DEN[5]),
    GAIN_W'((GAM_NUM[6] << FRACTION_BITS) / GAM_DEN[6]),
    GAIN_W'((GAM_NUM[7] << FRACTION_BITS) / GAM_DEN[7])
  };

  bld_state_t              state;
  bld_state_t              state_next;
  logic [GAIN_W-1:0]       gain;
  logic [PIXEL_W-1:0]      idx;
  logic [LOG_ADDR_W-1:0]   ptr;
  logic [KEY_W-1:0]        key;
  logic [LOG_ADDR_W-1:0]   rom_addr;
  logic [LOG_W-1:0]        rom_q;
  logic [PROD_W-1:0]       product;
  logic [PIXEL_W-1:0]      idx_inc;
  logic                    advance;
  logic                    start;

  glc_log_rom u_log_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  assign start   = cmd.restart && is_gamma(cmd.sel);
  assign idx_inc = idx + PIXEL_W'(1);

  // Key for the current entry: scaled log of 2i times the gain, wrapped
  assign product = PROD_W'(rom_q[LOG_W-1:FRACTION_BITS]) * PROD_W'(gain);

  // Pointer moves on while the ROM entry is above the key
  assign advance = (ptr != PTR_END) && ({1'b0, rom_q} > key);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BLD_IDLE: state_next = BLD_IDLE;
      BLD_ZERO: state_next = BLD_MUL;
      BLD_MUL:  state_next = BLD_WALK;
      BLD_WALK: begin
        if (advance) begin
          state_next = BLD_WALK;
        end else if (idx == IDX_LAST) begin
          state_next = BLD_IDLE;
        end else begin
          state_next = BLD_MUL;
        end
      end
      default: state_next = BLD_IDLE;
    endcase
    if (cmd.restart) begin
      state_next = start ? BLD_ZERO : BLD_IDLE;
    end
  end

  // Outputs: ROM address, table write, status
  always_comb begin
    rom_addr      = '0;
    tbl_wr.we     = 1'b0;
    tbl_wr.addr   = idx;
    tbl_wr.data   = ptr[LOG_ADDR_W-1:1];
    status.busy   = (state != BLD_IDLE);
    status.done   = 1'b0;
    case (state)
      BLD_IDLE: begin
        rom_addr = '0;
      end
      BLD_ZERO: begin
        // Entry zero maps to zero; fetch the key source of entry one
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = '0;
        tbl_wr.data = '0;
        rom_addr    = {IDX_FIRST, 1'b0};
      end
      BLD_MUL: begin
        rom_addr = ptr;
      end
      BLD_WALK: begin
        if (advance) begin
          rom_addr = ptr + LOG_ADDR_W'(1);
        end else begin
          tbl_wr.we   = 1'b1;
          rom_addr    = {idx_inc, 1'b0};
          status.done = (idx == IDX_LAST);
        end
      end
      default: begin
        rom_addr = '0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BLD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (start) begin
      gain <= GAIN[cmd.sel];
      idx  <= IDX_FIRST;
      ptr  <= PTR_FIRST;
    end else begin
      if (state == BLD_MUL) begin
        key <= product[KEY_W-1:0];
      end
      if (state == BLD_WALK) begin
        if (advance) begin
          ptr <= ptr + LOG_ADDR_W'(1);
        end else begin
          idx <= idx_inc;
        end
      end
    end
  end

endmodule

>>> rtl/core/glc_lookup.sv
// ----------------------------------------------------------------------------
// glc_lookup
// Sample path: table read stage and output register, one item per cycle
// while not stalled, pass-through when no table is loaded.
// ----------------------------------------------------------------------------
module glc_lookup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold_off,
  input  logic                        table_ready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [glc_pkg::PIXEL_W-1:0] pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [glc_pkg::PIXEL_W-1:0] pixel_out,
  output logic [glc_pkg::PIXEL_W-1:0] rd_addr,
  input  logic [glc_pkg::PIXEL_W-1:0] rd_data
);
  import glc_pkg::*;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_bypass;
  logic               out_free;
  logic               s1_adv;
  logic               accept;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = hold_off || (s1_valid && !out_free);
  assign accept   = in_valid && !in_stall;

  // Read the new sample's entry, or hold the read of a waiting item
  assign rd_addr = accept ? pixel_in : s1_pixel;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel_in;
      s1_bypass <= !table_ready;
    end
    if (s1_adv) begin
      pixel_out <= s1_bypass ? s1_pixel : rd_data;
    end
  end

endmodule

>>> rtl/core/gamma_lut_correction_core.sv
// ----------------------------------------------------------------------------
// gamma_lut_correction_core
// Gamma correction of 8-bit samples through a 256-entry table that is
// rebuilt from a log ROM whenever a gamma is selected.
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload       direction
//  -------  ------------------------  ------------  ---------
//  input    in_valid / in_stall       pixel_in      into core
//  output   out_valid / out_stall     pixel_out     out of core
//  config   cfg_write                 cfg_data      into core
//
//  A gamma select write starts a table build whose length is set by the
//  pointer walk on the single ROM port. in_stall stays high for the whole
//  build; a bypass select takes effect at once. Outside a build and while
//  out_stall is low, items pass at one per cycle through the read stage and
//  the output register. Reset leaves the core in bypass with no table
//  loaded; table contents are not cleared. out_stall holds the output
//  register and, once the read stage is also full, raises in_stall.
//
module gamma_lut_correction_core #(
  parameter int unsigned FRACTION_BITS = glc_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [glc_pkg::SEL_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [glc_pkg::PIXEL_W-1:0] pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [glc_pkg::PIXEL_W-1:0] pixel_out
);
  import glc_pkg::*;

  glc_cmd_t           cmd;
  glc_tbl_wr_t        tbl_wr;
  glc_bld_status_t    bld_status;
  logic               table_ready;
  logic [PIXEL_W-1:0] rd_addr;
  logic [PIXEL_W-1:0] rd_data;

  assign cmd.restart = cfg_write;
  assign cmd.sel     = cfg_data;

  // Table ready: drop on any select write, raise when a build completes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_ready <= 1'b0;
    end else if (cfg_write) begin
      table_ready <= 1'b0;
    end else if (bld_status.done) begin
      table_ready <= 1'b1;
    end
  end

  glc_table_builder #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_builder (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .tbl_wr (tbl_wr),
    .status (bld_status)
  );

  glc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (TBL_DEPTH)
  ) u_gamma_table (
    .clk     (clk),
    .wr_en   (tbl_wr.we),
    .wr_addr (tbl_wr.addr),
    .wr_data (tbl_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  glc_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .hold_off    (bld_status.busy),
    .table_ready (table_ready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Hold input off for the whole build
  a_stall_in_build: assert property (@(posedge clk) disable iff (rst)
    bld_status.busy |-> in_stall)
    else $error("item can enter during a table build");

  // No loaded table while a build is running
  a_ready_vs_build: assert property (@(posedge clk) disable iff (rst)
    !(table_ready && bld_status.busy))
    else $error("table marked ready during a build");

  // A completed build loads the table
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    (bld_status.done && !cfg_write) |=> table_ready)
    else $error("build finished without loading the table");

  // A gamma select starts a build at once
  a_select_builds: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && is_gamma(cfg_data)) |=> (bld_status.busy && in_stall))
    else $error("gamma select did not start a build");

endmodule
